// ===== rtl/core/cffp_pkg.sv =====
// ----------------------------------------------------------------------------
// cffp_pkg
// Shared types and constants of the camera feature frame parser.
// ----------------------------------------------------------------------------
package cffp_pkg;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 10;

  localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_TYPE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ATTEMPT_LIMIT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DECODE_FEATURES = 2'd2;

  localparam logic [7:0] EXPECTED_TYPE_RST   = 8'd49;
  localparam logic [9:0] ATTEMPT_LIMIT_RST   = 10'd1000;
  localparam logic       DECODE_FEATURES_RST = 1'b1;

  localparam logic [7:0] SYNC_A      = 8'd175;
  localparam logic [7:0] SYNC_B      = 8'd193;
  localparam logic [7:0] BAD_LENGTH  = 8'd255;
  localparam logic [9:0] ATTEMPT_MAX = 10'd1023;

  // Record types inside the payload
  localparam logic [7:0] REC_VECTOR       = 8'd1;
  localparam logic [7:0] REC_INTERSECTION = 8'd2;
  localparam logic [7:0] REC_BARCODE      = 8'd4;

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_H0,
    PH_H1,
    PH_H2,
    PH_LEN,
    PH_CK1,
    PH_CK2,
    PH_RTYPE,
    PH_RLEN,
    PH_RDATA
  } phase_t;

  typedef enum logic [2:0] {
    KIND_RAW,
    KIND_VECTOR,
    KIND_INTERSECTION,
    KIND_LINE,
    KIND_BARCODE,
    KIND_END,
    KIND_FAIL
  } kind_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       frame_start;
  } in_item_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] x;
    logic [7:0] y;
    logic [7:0] x_end;
    logic [7:0] y_end;
    logic [7:0] item_index;
    logic [7:0] flags;
    logic [7:0] line_count;
    logic [7:0] angle;
    logic [7:0] code;
    logic [7:0] frame_length;
    logic       last;
  } out_item_t;

  // Compact result descriptor: meaning of arg depends on kind
  typedef struct packed {
    kind_t           kind;
    logic            last;
    logic [7:0]      frame_length;
    logic [5:0][7:0] arg;
  } desc_t;

endpackage

// ===== rtl/core/cffp_front.sv =====
// ----------------------------------------------------------------------------
// cffp_front
// Byte classifier: sync hunt, header, and record walk; emits descriptors.
// ----------------------------------------------------------------------------
module cffp_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [cffp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [cffp_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  logic                                accept,
  input  cffp_pkg::in_item_t                  in_data,
  output logic                                push,
  output cffp_pkg::desc_t                     push_data
);

  logic [7:0]            expected_type_r;
  logic [9:0]            attempt_limit_r;
  logic                  decode_features_r;

  cffp_pkg::phase_t      phase_r, phase_nxt;
  logic [9:0]            attempt_r, attempt_nxt;
  logic [7:0]            plen_r, plen_nxt;
  logic [7:0]            pos_r, pos_nxt;
  logic [7:0]            rtype_r, rtype_nxt;
  logic [7:0]            rlen_r, rlen_nxt;
  logic [7:0]            roff_r, roff_nxt;
  logic [7:0]            lines_r, lines_nxt;
  logic [5:0][7:0]       rb_r;
  logic [5:0]            rb_we;

  cffp_pkg::phase_t      ph;
  logic [9:0]            att;
  logic [9:0]            att_sat;
  logic [7:0]            plen;
  logic [7:0]            b;
  logic [7:0]            pos_inc;
  logic [7:0]            roff_inc;
  logic                  fail;
  logic                  made;
  logic                  emit;
  cffp_pkg::desc_t       d;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expected_type_r   <= cffp_pkg::EXPECTED_TYPE_RST;
      attempt_limit_r   <= cffp_pkg::ATTEMPT_LIMIT_RST;
      decode_features_r <= cffp_pkg::DECODE_FEATURES_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        cffp_pkg::CFG_EXPECTED_TYPE:   expected_type_r   <= cfg_wdata[7:0];
        cffp_pkg::CFG_ATTEMPT_LIMIT:   attempt_limit_r   <= cfg_wdata[9:0];
        cffp_pkg::CFG_DECODE_FEATURES: decode_features_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    b        = in_data.rx_byte;
    ph       = in_data.frame_start ? cffp_pkg::PH_H0 : phase_r;
    att      = in_data.frame_start ? 10'd0 : attempt_r;
    plen     = in_data.frame_start ? 8'd0 : plen_r;
    att_sat  = (att == cffp_pkg::ATTEMPT_MAX) ? att : att + 10'd1;
    pos_inc  = pos_r + 8'd1;
    roff_inc = roff_r + 8'd1;

    phase_nxt   = ph;
    attempt_nxt = att;
    plen_nxt    = plen;
    pos_nxt     = pos_r;
    rtype_nxt   = rtype_r;
    rlen_nxt    = rlen_r;
    roff_nxt    = roff_r;
    lines_nxt   = lines_r;
    rb_we       = '0;
    fail        = 1'b0;
    made        = 1'b0;
    emit        = 1'b0;

    d              = '0;
    d.kind         = cffp_pkg::KIND_END;
    d.frame_length = plen;

    case (ph)
      cffp_pkg::PH_H0: begin
        if (b == cffp_pkg::SYNC_A) phase_nxt = cffp_pkg::PH_H1;
        else fail = 1'b1;
      end
      cffp_pkg::PH_H1: begin
        if (b == cffp_pkg::SYNC_B) phase_nxt = cffp_pkg::PH_H2;
        else fail = 1'b1;
      end
      cffp_pkg::PH_H2: begin
        if (b == expected_type_r) phase_nxt = cffp_pkg::PH_LEN;
        else fail = 1'b1;
      end
      cffp_pkg::PH_LEN: begin
        plen_nxt = b;
        if (b == cffp_pkg::BAD_LENGTH) begin
          emit           = 1'b1;
          d.kind         = cffp_pkg::KIND_FAIL;
          d.frame_length = b;
          d.last         = 1'b1;
          phase_nxt      = cffp_pkg::PH_IDLE;
        end else begin
          phase_nxt = cffp_pkg::PH_CK1;
        end
      end
      cffp_pkg::PH_CK1: phase_nxt = cffp_pkg::PH_CK2;
      cffp_pkg::PH_CK2: begin
        pos_nxt   = '0;
        roff_nxt  = '0;
        lines_nxt = '0;
        if (plen == 8'd0) begin
          emit      = 1'b1;
          d.kind    = cffp_pkg::KIND_END;
          d.last    = 1'b1;
          phase_nxt = cffp_pkg::PH_IDLE;
        end else begin
          phase_nxt = cffp_pkg::PH_RTYPE;
        end
      end
      cffp_pkg::PH_RTYPE, cffp_pkg::PH_RLEN, cffp_pkg::PH_RDATA: begin
        pos_nxt = pos_inc;
        if (!decode_features_r) begin
          made      = 1'b1;
          d.kind    = cffp_pkg::KIND_RAW;
          d.arg[0]  = b;
        end else if (ph == cffp_pkg::PH_RTYPE) begin
          rtype_nxt = b;
          phase_nxt = cffp_pkg::PH_RLEN;
        end else if (ph == cffp_pkg::PH_RLEN) begin
          rlen_nxt  = b;
          roff_nxt  = '0;
          lines_nxt = '0;
          phase_nxt = (b == 8'd0) ? cffp_pkg::PH_RTYPE : cffp_pkg::PH_RDATA;
        end else begin
          // Record data byte; capture the first six, reuse slot 3 for line index
          if (roff_r < 8'd6) rb_we[roff_r[2:0]] = 1'b1;
          if (rtype_r == cffp_pkg::REC_VECTOR && roff_r == 8'd5) begin
            made     = 1'b1;
            d.kind   = cffp_pkg::KIND_VECTOR;
            d.arg[0] = rb_r[0];
            d.arg[1] = rb_r[1];
            d.arg[2] = rb_r[2];
            d.arg[3] = rb_r[3];
            d.arg[4] = rb_r[4];
            d.arg[5] = b;
          end else if (rtype_r == cffp_pkg::REC_INTERSECTION) begin
            if (roff_r == 8'd2) begin
              made     = 1'b1;
              d.kind   = cffp_pkg::KIND_INTERSECTION;
              d.arg[0] = rb_r[0];
              d.arg[1] = rb_r[1];
              d.arg[2] = b;
            end else if (roff_r >= 8'd3) begin
              if (roff_r[0]) begin
                rb_we[3] = 1'b1;
              end else if (lines_r < rb_r[2]) begin
                made      = 1'b1;
                d.kind    = cffp_pkg::KIND_LINE;
                d.arg[0]  = rb_r[0];
                d.arg[1]  = rb_r[1];
                d.arg[2]  = rb_r[2];
                d.arg[3]  = rb_r[3];
                d.arg[4]  = b;
                lines_nxt = lines_r + 8'd1;
              end
            end
          end else if (rtype_r == cffp_pkg::REC_BARCODE && roff_r == 8'd3) begin
            made     = 1'b1;
            d.kind   = cffp_pkg::KIND_BARCODE;
            d.arg[0] = rb_r[0];
            d.arg[1] = rb_r[1];
            d.arg[2] = rb_r[2];
            d.arg[3] = b;
          end
          roff_nxt = roff_inc;
          if (roff_inc >= rlen_r) phase_nxt = cffp_pkg::PH_RTYPE;
        end
        emit = made;
        if (pos_inc >= plen) begin
          // Payload exhausted: flag the result, or close with an end marker
          emit      = 1'b1;
          d.last    = 1'b1;
          phase_nxt = cffp_pkg::PH_IDLE;
          if (!made) begin
            d.kind = cffp_pkg::KIND_END;
            d.arg  = '0;
          end
        end
      end
      default: phase_nxt = cffp_pkg::PH_IDLE;
    endcase

    if (fail) begin
      attempt_nxt = att_sat;
      if (att_sat >= attempt_limit_r) begin
        emit      = 1'b1;
        d.kind    = cffp_pkg::KIND_FAIL;
        d.last    = 1'b1;
        phase_nxt = cffp_pkg::PH_IDLE;
      end else begin
        phase_nxt = cffp_pkg::PH_H0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= cffp_pkg::PH_IDLE;
      attempt_r <= '0;
      plen_r    <= '0;
      pos_r     <= '0;
      rtype_r   <= '0;
      rlen_r    <= '0;
      roff_r    <= '0;
      lines_r   <= '0;
    end else if (accept) begin
      phase_r   <= phase_nxt;
      attempt_r <= attempt_nxt;
      plen_r    <= plen_nxt;
      pos_r     <= pos_nxt;
      rtype_r   <= rtype_nxt;
      rlen_r    <= rlen_nxt;
      roff_r    <= roff_nxt;
      lines_r   <= lines_nxt;
    end
  end

  // Record byte store: written before read within a record, no reset
  always_ff @(posedge clk) begin
    for (int i = 0; i < 6; i++) begin
      if (accept && rb_we[i]) rb_r[i] <= b;
    end
  end

  assign push      = accept && emit;
  assign push_data = d;

endmodule

// ===== rtl/core/cffp_queue.sv =====
// ----------------------------------------------------------------------------
// cffp_queue
// Short descriptor queue between the classifier and the output stage.
// ----------------------------------------------------------------------------
module cffp_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  cffp_pkg::desc_t  push_data,
  input  logic             pop,
  output logic             full,
  output logic             q_valid,
  output cffp_pkg::desc_t  q_data
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  cffp_pkg::desc_t  mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r;
  logic [PW-1:0]    rd_ptr_r;
  logic [CW-1:0]    count_r;
  logic             empty;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign q_valid = !empty;
  assign q_data  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + CW'(1);
        2'b01:   count_r <= count_r - CW'(1);
        default: count_r <= count_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_data;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full) else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty) else $error("queue pop while empty");

  a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |=> count_r == $past(count_r) + CW'(1))
    else $error("queue count did not advance on push");

endmodule

// ===== rtl/core/cffp_back.sv =====
// ----------------------------------------------------------------------------
// cffp_back
// Output stage: expands descriptors into result beats and holds them.
// ----------------------------------------------------------------------------
module cffp_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_valid,
  input  cffp_pkg::desc_t      q_data,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output cffp_pkg::out_item_t  out_data
);

  logic                 valid_r;
  cffp_pkg::out_item_t  data_r;
  cffp_pkg::out_item_t  data_nxt;

  always_comb begin
    data_nxt              = '0;
    data_nxt.kind         = q_data.kind;
    data_nxt.frame_length = q_data.frame_length;
    data_nxt.last         = q_data.last;
    case (q_data.kind)
      cffp_pkg::KIND_RAW: data_nxt.x = q_data.arg[0];
      cffp_pkg::KIND_VECTOR: begin
        data_nxt.x          = q_data.arg[0];
        data_nxt.y          = q_data.arg[1];
        data_nxt.x_end      = q_data.arg[2];
        data_nxt.y_end      = q_data.arg[3];
        data_nxt.item_index = q_data.arg[4];
        data_nxt.flags      = q_data.arg[5];
      end
      cffp_pkg::KIND_INTERSECTION: begin
        data_nxt.x          = q_data.arg[0];
        data_nxt.y          = q_data.arg[1];
        data_nxt.line_count = q_data.arg[2];
      end
      cffp_pkg::KIND_LINE: begin
        data_nxt.x          = q_data.arg[0];
        data_nxt.y          = q_data.arg[1];
        data_nxt.line_count = q_data.arg[2];
        data_nxt.item_index = q_data.arg[3];
        data_nxt.angle      = q_data.arg[4];
      end
      cffp_pkg::KIND_BARCODE: begin
        data_nxt.x     = q_data.arg[0];
        data_nxt.y     = q_data.arg[1];
        data_nxt.flags = q_data.arg[2];
        data_nxt.code  = q_data.arg[3];
      end
      default: ;
    endcase
  end

  // Load whenever the register is empty or its beat is being taken
  assign pop = q_valid && (!valid_r || !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (pop) begin
      valid_r <= 1'b1;
    end else if (!out_stall) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) data_r <= data_nxt;
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

// ===== rtl/core/camera_feature_frame_parser.sv =====
// ----------------------------------------------------------------------------
// camera_feature_frame_parser
// Reply byte parser for a smart camera link: sync hunt, header, feature records.
// ----------------------------------------------------------------------------
//
//   port group | direction | beat contents
//   -----------+-----------+---------------------------------------------
//   in_        | in        | in_item_t: rx_byte, frame_start
//   out_       | out       | out_item_t: kind, coordinates, fields, last
//   cfg_       | in        | index, data: expected type, limit, mode
//
// One byte is taken per clock while in_stall is low; the classifier updates
// its phase and record state as each byte is accepted, so input beats may
// arrive back to back. A result passes from the byte that causes it through
// the descriptor queue and then the output register before it appears on out_.
// Reset is synchronous on rst_n; the parser starts idle with default config.
// in_stall rises only when the descriptor queue is full, which happens only
// after out_stall has held the output register.
//
module camera_feature_frame_parser #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [cffp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [cffp_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  cffp_pkg::in_item_t               in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output cffp_pkg::out_item_t              out_data
);

  logic             accept;
  logic             push;
  cffp_pkg::desc_t  push_data;
  logic             pop;
  logic             q_full;
  logic             q_valid;
  cffp_pkg::desc_t  q_data;

  // Hold input while the queue cannot take another descriptor
  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;

  cffp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .accept    (accept),
    .in_data   (in_data),
    .push      (push),
    .push_data (push_data)
  );

  cffp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .full      (q_full),
    .q_valid   (q_valid),
    .q_data    (q_data)
  );

  cffp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ===== verif/camera_feature_frame_parser_test.sv =====
// ----------------------------------------------------------------------------
// camera_feature_frame_parser_test
// Self-checking bench for the camera reply parser. A queue of byte beats feeds
// a clocked driver; every accepted beat is run through a shadow parser, and
// the results it predicts are matched in order against the output beats.
// Phases vary the registers and the idling on both channels.
// ----------------------------------------------------------------------------
module camera_feature_frame_parser_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned SETTLE_CYCLES = 8;    // two-stage result path plus margin
  localparam int unsigned HOLD_CYCLES   = 300;  // long receiver hold-off

  typedef enum logic [1:0] {
    IDLE_NONE,
    IDLE_SEND,
    IDLE_RECV,
    IDLE_BOTH
  } idle_mode_t;

  // --------------------------------------------------------------------------
  // Clock, reset and block ports
  // --------------------------------------------------------------------------
  logic                            clk       = 1'b0;
  logic                            rst_n     = 1'b0;
  logic                            cfg_we    = 1'b0;
  logic [cffp_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [cffp_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                            in_valid  = 1'b0;
  logic                            in_stall;
  cffp_pkg::in_item_t              in_data   = '0;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  cffp_pkg::out_item_t             out_data;

  initial begin
    forever #5 clk = ~clk;
  end

  camera_feature_frame_parser u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // --------------------------------------------------------------------------
  // Bench state
  // --------------------------------------------------------------------------
  cffp_pkg::in_item_t  pending_q[$];     // byte beats still to be offered
  cffp_pkg::out_item_t reports_due[$];   // parser results predicted, oldest first
  logic [7:0]          frame_bytes[$];   // scratch payload while a reply is built
  int unsigned beats_queued = 0;
  int unsigned mismatches   = 0;
  int unsigned cycle_cnt    = 0;
  idle_mode_t  idle_mode    = IDLE_NONE;
  logic        hold_req     = 1'b0;
  int unsigned hold_left    = 0;

  // Shadow copy of the registers, updated once program_regs has issued its writes
  logic [7:0] sh_type   = cffp_pkg::EXPECTED_TYPE_RST;
  logic [9:0] sh_limit  = cffp_pkg::ATTEMPT_LIMIT_RST;
  logic       sh_decode = cffp_pkg::DECODE_FEATURES_RST;

  // Shadow parser state
  cffp_pkg::phase_t sh_phase = cffp_pkg::PH_IDLE;
  logic [9:0] sh_attempts = '0;
  logic [7:0] sh_pay_len  = '0;
  logic [7:0] sh_pay_pos  = '0;
  logic [7:0] sh_rec_type = '0;
  logic [7:0] sh_rec_len  = '0;
  logic [7:0] sh_rec_off  = '0;
  logic [7:0] sh_lines    = '0;
  logic [7:0] sh_rec_buf [6] = '{default: '0};

  // --------------------------------------------------------------------------
  // Shadow parser
  // --------------------------------------------------------------------------

  // Start a result of the given kind with every other field cleared; the
  // announced payload length rides on every result.
  function automatic cffp_pkg::out_item_t blank_report(input cffp_pkg::kind_t kind);
    cffp_pkg::out_item_t res;
    res              = '0;
    res.kind         = kind;
    res.frame_length = sh_pay_len;
    return res;
  endfunction

  // One data byte of the current feature record. Bytes are buffered by their
  // offset; a vector completes at offset 5, a barcode at 3, an intersection
  // header at 2, and from offset 3 intersection data comes in (index, angle)
  // pairs, a line being reported on each angle while the count allows.
  function automatic bit record_data(input logic [7:0] b,
                                     inout cffp_pkg::out_item_t res);
    logic [7:0] o;
    bit         made;
    o    = sh_rec_off;
    made = 1'b0;
    if (o < 8'd6) sh_rec_buf[o[2:0]] = b;
    if (sh_rec_type == cffp_pkg::REC_VECTOR && o == 8'd5) begin
      res            = blank_report(cffp_pkg::KIND_VECTOR);
      res.x          = sh_rec_buf[0];
      res.y          = sh_rec_buf[1];
      res.x_end      = sh_rec_buf[2];
      res.y_end      = sh_rec_buf[3];
      res.item_index = sh_rec_buf[4];
      res.flags      = sh_rec_buf[5];
      made           = 1'b1;
    end else if (sh_rec_type == cffp_pkg::REC_INTERSECTION) begin
      if (o == 8'd2) begin
        res            = blank_report(cffp_pkg::KIND_INTERSECTION);
        res.x          = sh_rec_buf[0];
        res.y          = sh_rec_buf[1];
        res.line_count = sh_rec_buf[2];
        made           = 1'b1;
      end else if (o >= 8'd3) begin
        if (o[0]) begin
          sh_rec_buf[3] = b;
        end else if (sh_lines < sh_rec_buf[2]) begin
          res            = blank_report(cffp_pkg::KIND_LINE);
          res.x          = sh_rec_buf[0];
          res.y          = sh_rec_buf[1];
          res.item_index = sh_rec_buf[3];
          res.line_count = sh_rec_buf[2];
          res.angle      = b;
          sh_lines       = sh_lines + 8'd1;
          made           = 1'b1;
        end
      end
    end else if (sh_rec_type == cffp_pkg::REC_BARCODE && o == 8'd3) begin
      res       = blank_report(cffp_pkg::KIND_BARCODE);
      res.x     = sh_rec_buf[0];
      res.y     = sh_rec_buf[1];
      res.flags = sh_rec_buf[2];
      res.code  = sh_rec_buf[3];
      made      = 1'b1;
    end
    sh_rec_off = o + 8'd1;
    if (sh_rec_off >= sh_rec_len) sh_phase = cffp_pkg::PH_RTYPE;
    return made;
  endfunction

  // Advance the shadow parser by one received byte; returns 1 when the byte
  // produces a result, which is then left in res.
  function automatic bit parse_byte(input cffp_pkg::in_item_t beat,
                                    output cffp_pkg::out_item_t res);
    logic [7:0] b;
    bit         fail;
    bit         made;
    b    = beat.rx_byte;
    fail = 1'b0;
    made = 1'b0;
    res  = '0;
    if (beat.frame_start) begin
      sh_phase    = cffp_pkg::PH_H0;
      sh_attempts = '0;
      sh_pay_len  = '0;
    end
    case (sh_phase)
      cffp_pkg::PH_H0: begin
        if (b == cffp_pkg::SYNC_A) sh_phase = cffp_pkg::PH_H1;
        else fail = 1'b1;
      end
      cffp_pkg::PH_H1: begin
        if (b == cffp_pkg::SYNC_B) sh_phase = cffp_pkg::PH_H2;
        else fail = 1'b1;
      end
      cffp_pkg::PH_H2: begin
        if (b == sh_type) sh_phase = cffp_pkg::PH_LEN;
        else fail = 1'b1;
      end
      cffp_pkg::PH_LEN: begin
        sh_pay_len = b;
        if (b == cffp_pkg::BAD_LENGTH) begin
          res      = blank_report(cffp_pkg::KIND_FAIL);
          res.last = 1'b1;
          sh_phase = cffp_pkg::PH_IDLE;
          made     = 1'b1;
        end else begin
          sh_phase = cffp_pkg::PH_CK1;
        end
      end
      cffp_pkg::PH_CK1: sh_phase = cffp_pkg::PH_CK2;
      cffp_pkg::PH_CK2: begin
        sh_pay_pos = '0;
        sh_rec_off = '0;
        sh_lines   = '0;
        if (sh_pay_len == 8'd0) begin
          res      = blank_report(cffp_pkg::KIND_END);
          res.last = 1'b1;
          sh_phase = cffp_pkg::PH_IDLE;
          made     = 1'b1;
        end else begin
          sh_phase = cffp_pkg::PH_RTYPE;
        end
      end
      cffp_pkg::PH_RTYPE, cffp_pkg::PH_RLEN, cffp_pkg::PH_RDATA: begin
        sh_pay_pos = sh_pay_pos + 8'd1;
        if (!sh_decode) begin
          // raw bytes leave the record walk where it stands
          res   = blank_report(cffp_pkg::KIND_RAW);
          res.x = b;
          made  = 1'b1;
        end else if (sh_phase == cffp_pkg::PH_RTYPE) begin
          sh_rec_type = b;
          sh_phase    = cffp_pkg::PH_RLEN;
        end else if (sh_phase == cffp_pkg::PH_RLEN) begin
          sh_rec_len = b;
          sh_rec_off = '0;
          sh_lines   = '0;
          sh_phase   = (b == 8'd0) ? cffp_pkg::PH_RTYPE : cffp_pkg::PH_RDATA;
        end else begin
          made = record_data(b, res);
        end
        // the last payload byte closes the reply, with an end marker if it
        // made nothing itself; a record cut short is dropped
        if (sh_pay_pos >= sh_pay_len) begin
          if (!made) res = blank_report(cffp_pkg::KIND_END);
          res.last = 1'b1;
          sh_phase = cffp_pkg::PH_IDLE;
          made     = 1'b1;
        end
      end
      default: sh_phase = cffp_pkg::PH_IDLE;
    endcase
    if (fail) begin
      // a mismatching byte is not retried as a first sync byte
      if (sh_attempts < cffp_pkg::ATTEMPT_MAX) sh_attempts = sh_attempts + 10'd1;
      if (sh_attempts >= sh_limit) begin
        res      = blank_report(cffp_pkg::KIND_FAIL);
        res.last = 1'b1;
        sh_phase = cffp_pkg::PH_IDLE;
        made     = 1'b1;
      end else begin
        sh_phase = cffp_pkg::PH_H0;
      end
    end
    return made;
  endfunction

  task automatic take_beat(input cffp_pkg::in_item_t beat);
    cffp_pkg::out_item_t res;
    if (parse_byte(beat, res)) reports_due.push_back(res);
  endtask

  // --------------------------------------------------------------------------
  // Result checking
  // --------------------------------------------------------------------------
  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      mismatches++;
    end
  endfunction

  task automatic check_report(input cffp_pkg::out_item_t got);
    cffp_pkg::out_item_t want;
    if (reports_due.size() == 0) begin
      $display("%0t: result with none due, expected nothing, got kind %0d x %0d last %0d",
               $time, got.kind, got.x, got.last);
      mismatches++;
    end else begin
      want = reports_due.pop_front();
      check_field("kind", 8'(want.kind), 8'(got.kind));
      check_field("x", want.x, got.x);
      check_field("y", want.y, got.y);
      check_field("x_end", want.x_end, got.x_end);
      check_field("y_end", want.y_end, got.y_end);
      check_field("item_index", want.item_index, got.item_index);
      check_field("flags", want.flags, got.flags);
      check_field("line_count", want.line_count, got.line_count);
      check_field("angle", want.angle, got.angle);
      check_field("code", want.code, got.code);
      check_field("frame_length", want.frame_length, got.frame_length);
      check_field("last", 8'(want.last), 8'(got.last));
    end
  endtask

  // --------------------------------------------------------------------------
  // Idling decisions
  // --------------------------------------------------------------------------
  function automatic bit sender_gap();
    case (idle_mode)
      IDLE_SEND: return $urandom_range(0, 99) < 70;
      IDLE_BOTH: return $urandom_range(0, 99) < 25;
      default:   return 1'b0;
    endcase
  endfunction

  function automatic bit receiver_gap();
    case (idle_mode)
      IDLE_RECV: return $urandom_range(0, 99) < 70;
      IDLE_BOTH: return $urandom_range(0, 99) < 25;
      default:   return 1'b0;
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Driver: predict on each accepted beat, then offer the next one. A stalled
  // beat is held unchanged; valid only drops when no beat is offered.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) take_beat(in_data);
      if (!in_valid || !in_stall) begin
        if (pending_q.size() != 0 && !sender_gap()) begin
          in_data  <= pending_q.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: check each accepted result beat, then choose the next stall.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) check_report(out_data);
      out_stall <= (hold_left != 0) || receiver_gap();
    end
  end

  // Long receiver hold-off, counted here and started on request
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
    end else if (hold_req && hold_left == 0) begin
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus building
  // --------------------------------------------------------------------------

  // Bias towards the byte extremes
  function automatic logic [7:0] rand_byte();
    case ($urandom_range(0, 9))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic void queue_beat(input logic [7:0] b, input logic fs);
    cffp_pkg::in_item_t beat;
    beat.rx_byte     = b;
    beat.frame_start = fs;
    pending_q.push_back(beat);
    beats_queued++;
  endfunction

  // Sync pair, type, length and two checksum bytes of random content
  function automatic void queue_header(input logic [7:0] len);
    queue_beat(cffp_pkg::SYNC_A, 1'b1);
    queue_beat(cffp_pkg::SYNC_B, 1'b0);
    queue_beat(sh_type, 1'b0);
    queue_beat(len, 1'b0);
    queue_beat(rand_byte(), 1'b0);
    queue_beat(rand_byte(), 1'b0);
  endfunction

  // Append one record to frame_bytes: mostly well-formed, sometimes short,
  // padded, empty or of an unknown type.
  function automatic void add_record();
    int         r;
    int         len;
    int         pairs;
    logic [7:0] count;
    r = $urandom_range(0, 99);
    if (r < 30) begin
      len = ($urandom_range(0, 3) != 0) ? 6 : $urandom_range(0, 9);
      frame_bytes.push_back(cffp_pkg::REC_VECTOR);
      frame_bytes.push_back(8'(len));
      repeat (len) frame_bytes.push_back(rand_byte());
    end else if (r < 60) begin
      count = ($urandom_range(0, 4) != 0) ? 8'($urandom_range(0, 4)) : rand_byte();
      pairs = $urandom_range(0, 5);
      len   = 3 + 2 * pairs;
      if ($urandom_range(0, 4) == 0) len = $urandom_range(0, len + 1);
      frame_bytes.push_back(cffp_pkg::REC_INTERSECTION);
      frame_bytes.push_back(8'(len));
      for (int i = 0; i < len; i++) begin
        frame_bytes.push_back((i == 2) ? count : rand_byte());
      end
    end else if (r < 85) begin
      len = ($urandom_range(0, 3) != 0) ? 4 : $urandom_range(0, 7);
      frame_bytes.push_back(cffp_pkg::REC_BARCODE);
      frame_bytes.push_back(8'(len));
      repeat (len) frame_bytes.push_back(rand_byte());
    end else begin
      case ($urandom_range(0, 2))
        0:       frame_bytes.push_back(8'd0);
        1:       frame_bytes.push_back(8'd3);
        default: frame_bytes.push_back(8'($urandom_range(5, 255)));
      endcase
      len = $urandom_range(0, 6);
      frame_bytes.push_back(8'(len));
      repeat (len) frame_bytes.push_back(rand_byte());
    end
  endfunction

  // Hold until everything offered has been taken and every result has come
  task automatic wait_drained();
    while (pending_q.size() != 0 || in_valid || reports_due.size() != 0) @(negedge clk);
  endtask

  task automatic drain_and_settle();
    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // One reply of records. The announced length usually matches, sometimes
  // cuts the last record or covers trailing bytes. cut abandons the reply
  // part way; pause_mid stops the sender half way until all results are in.
  task automatic queue_frame(input bit pause_mid, input bit cut);
    int plen;
    int send_n;
    int v;
    frame_bytes.delete();
    repeat ($urandom_range(1, 4)) add_record();
    v = $urandom_range(0, 9);
    if (v == 1) repeat ($urandom_range(1, 4)) frame_bytes.push_back(rand_byte());
    plen = frame_bytes.size();
    if (v == 0) plen = $urandom_range(1, plen);
    if (plen > 254) plen = 254;
    send_n = cut ? $urandom_range(0, plen - 1) : plen;
    queue_header(8'(plen));
    for (int i = 0; i < send_n; i++) begin
      if (pause_mid && i == plen / 2) wait_drained();
      queue_beat(frame_bytes[i], 1'b0);
    end
  endtask

  // Mix of well-formed replies (the bulk) with broken and noisy traffic
  task automatic random_traffic(input int unsigned target);
    int unsigned stop_at;
    int          r;
    stop_at = beats_queued + target;
    while (beats_queued < stop_at) begin
      r = $urandom_range(0, 99);
      if (r < 72) begin
        queue_frame(1'b0, 1'b0);
      end else if (r < 80) begin
        queue_frame(1'b0, 1'b1);
      end else if (r < 86) begin
        // broken sync, then a few stray bytes
        queue_beat(cffp_pkg::SYNC_A, 1'b1);
        if ($urandom_range(0, 1)) queue_beat(cffp_pkg::SYNC_B, 1'b0);
        queue_beat(rand_byte(), 1'b0);
        repeat ($urandom_range(0, 5)) queue_beat(rand_byte(), 1'b0);
      end else if (r < 90) begin
        queue_header(cffp_pkg::BAD_LENGTH);
      end else if (r < 94) begin
        queue_header(8'd0);
      end else begin
        repeat ($urandom_range(1, 8)) queue_beat(rand_byte(), $urandom_range(0, 9) == 0);
      end
    end
  endtask

  // Write all three registers while the parser is idle
  task automatic program_regs(input logic [7:0] typ, input logic [9:0] lim,
                              input logic dec);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= cffp_pkg::CFG_EXPECTED_TYPE;
    cfg_wdata <= cffp_pkg::CFG_DATA_W'(typ);
    @(posedge clk);
    cfg_index <= cffp_pkg::CFG_ATTEMPT_LIMIT;
    cfg_wdata <= cffp_pkg::CFG_DATA_W'(lim);
    @(posedge clk);
    cfg_index <= cffp_pkg::CFG_DECODE_FEATURES;
    cfg_wdata <= cffp_pkg::CFG_DATA_W'(dec);
    @(posedge clk);
    cfg_we    <= 1'b0;
    sh_type   = typ;
    sh_limit  = lim;
    sh_decode = dec;
    @(negedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Sequence of phases
  // --------------------------------------------------------------------------
  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: empty payload, bad length, then a vector at the byte extremes,
    // all under the reset register values.
    idle_mode = IDLE_NONE;
    queue_header(8'd0);
    queue_header(cffp_pkg::BAD_LENGTH);
    queue_header(8'd8);
    queue_beat(cffp_pkg::REC_VECTOR, 1'b0);
    queue_beat(8'd6, 1'b0);
    queue_beat(8'hFF, 1'b0);
    queue_beat(8'h00, 1'b0);
    queue_beat(8'hFF, 1'b0);
    queue_beat(8'h00, 1'b0);
    queue_beat(8'hFF, 1'b0);
    queue_beat(8'h00, 1'b0);
    drain_and_settle();

    // Default type, largest limit, features; sender gaps
    program_regs(cffp_pkg::EXPECTED_TYPE_RST, cffp_pkg::ATTEMPT_MAX, 1'b1);
    idle_mode = IDLE_SEND;
    random_traffic(450);
    drain_and_settle();

    // Type zero, limit one so every failed attempt times out; receiver stalls
    program_regs(8'd0, 10'd1, 1'b1);
    idle_mode = IDLE_RECV;
    random_traffic(250);
    drain_and_settle();

    // Type 255, raw payload; both sides idling
    program_regs(8'hFF, 10'($urandom_range(1, 1023)), 1'b0);
    idle_mode = IDLE_BOTH;
    random_traffic(250);
    drain_and_settle();

    // Back-pressure: hold the receiver off while a longest raw reply streams
    // in, so the result queue fills and the input stalls.
    program_regs(rand_byte(), cffp_pkg::ATTEMPT_LIMIT_RST, 1'b0);
    idle_mode = IDLE_NONE;
    hold_req  = 1'b1;
    while (hold_left == 0) @(negedge clk);
    hold_req = 1'b0;
    queue_header(8'd254);
    repeat (254) queue_beat(rand_byte(), 1'b0);
    drain_and_settle();

    // Random type, small limit, features; open with a reply whose sender
    // pauses half way until every result is in.
    program_regs(rand_byte(), 10'($urandom_range(2, 20)), 1'b1);
    idle_mode = IDLE_NONE;
    queue_frame(1'b1, 1'b0);
    random_traffic(650);
    drain_and_settle();

    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
